@@ hdl/ulw_pkg.sv @@
// ----------------------------------------------------------------------------
// ulw_pkg
// Shared types, constants and decode helpers for the UTF-8 line wrapper.
// ----------------------------------------------------------------------------
package ulw_pkg;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int LW_W      = 12;
  localparam int GS_W      = 8;
  localparam int LL_W      = 7;
  localparam int CP_W      = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT = 2'd2;

  localparam logic [CP_W-1:0] CP_REPL      = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_LF        = 21'h00000A;
  localparam logic [CP_W-1:0] CP_CR        = 21'h00000D;
  localparam logic [CP_W-1:0] CP_ASCII_END = 21'h000080;

  localparam logic REC_LINE    = 1'b0;
  localparam logic REC_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FLUSH,
    OP_STEP,
    OP_LOAD,
    OP_REPLAY,
    OP_FRESH,
    OP_FINAL,
    OP_SUMMARY
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic       room;
    logic       need_replay;
    logic       in_last;
    logic       last_q;
    logic [1:0] pcount;
  } sts_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] offset;
    logic [15:0] length;
    logic [15:0] consumed;
    logic [6:0]  count;
  } rec_t;

  function automatic logic [2:0] seq_len(input logic [7:0] lead);
    logic [2:0] n;
    if (!lead[7]) begin
      n = 3'd1;
    end else if (lead[7:5] == 3'b110) begin
      n = 3'd2;
    end else if (lead[7:4] == 4'b1110) begin
      n = 3'd3;
    end else if (lead[7:3] == 5'b11110) begin
      n = 3'd4;
    end else begin
      n = 3'd0;
    end
    return n;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  // Punctuation that may not open a line and so may overhang once.
  function automatic logic no_line_start(input logic [CP_W-1:0] cp);
    logic hit;
    case (cp)
      21'h003002, 21'h00FF0C, 21'h003001, 21'h00FF1B, 21'h00FF1A,
      21'h00FF1F, 21'h00FF01, 21'h00300B, 21'h00300D, 21'h00300F,
      21'h00FF09, 21'h003011, 21'h003015, 21'h00FF5D, 21'h002026,
      21'h002014, 21'h00FF5E, 21'h0000B7, 21'h002019, 21'h00201D,
      21'h00002C, 21'h00002E, 21'h00003B, 21'h00003A, 21'h00003F,
      21'h000021, 21'h000029, 21'h00005D, 21'h00007D: begin
        hit = 1'b1;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    return hit;
  endfunction

endpackage

@@ hdl/ulw_if.sv @@
// ----------------------------------------------------------------------------
// ulw_if
// Valid/ready channels for text bytes in and line records out.
// ----------------------------------------------------------------------------
interface ulw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source(output valid, byte_value, last_byte, input ready);
  modport sink(input valid, byte_value, last_byte, output ready);
endinterface

interface ulw_rec_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [15:0] line_offset;
  logic [15:0] line_length;
  logic [15:0] bytes_consumed;
  logic [6:0]  line_count;
  logic        end_of_run;

  modport source(output valid, record_kind, line_offset, line_length, bytes_consumed,
                 line_count, end_of_run, input ready);
  modport sink(input valid, record_kind, line_offset, line_length, bytes_consumed,
               line_count, end_of_run, output ready);
endinterface

@@ hdl/utf8_line_wrapper_core.sv @@
// ----------------------------------------------------------------------------
// utf8_line_wrapper_core
// Decodes a UTF-8 text buffer one byte per request and breaks it greedily
// into lines at a pixel width. Well-formed bytes are taken one per cycle as
// long as records drain. A byte that breaks a pending multi-byte sequence
// takes a load step, a replay step for each of the N held bytes (1 to 3,
// replayed as U+FFFD) and a fresh decode step, because the single character
// fitting unit handles one character per cycle while the record stage has
// room. The last byte of a buffer adds a final line step and a summary step.
// Each step yields at most one record, which passes through a staging
// register and an output register, so input is taken while a record waits.
// ----------------------------------------------------------------------------
module utf8_line_wrapper_core #(
  parameter int OFFSET_BITS = 16,
  parameter int MAX_LINES   = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ulw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ulw_pkg::CFG_W-1:0]     cfg_data,
  ulw_byte_if.sink                      byte_in,
  ulw_rec_if.source                     rec_out
);

  ulw_pkg::cmd_t cmd;
  ulw_pkg::sts_t sts;
  logic          in_ready;

  assign byte_in.ready = in_ready;

  ulw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_in.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ulw_datapath #(
    .OFFSET_BITS (OFFSET_BITS),
    .MAX_LINES   (MAX_LINES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_value (byte_in.byte_value),
    .last_byte  (byte_in.last_byte),
    .cmd        (cmd),
    .sts        (sts),
    .rec_out    (rec_out)
  );

endmodule

@@ hdl/ulw_ctrl.sv @@
// ----------------------------------------------------------------------------
// ulw_ctrl
// Sequencer that walks each byte request through replay, decode, final line
// and summary steps, one step per cycle when the record stage has room.
// ----------------------------------------------------------------------------
module ulw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output ulw_pkg::cmd_t cmd,
  input  ulw_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REPLAY,
    S_FRESH,
    S_FINAL,
    S_SUMMARY
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] idx;
  logic [1:0] idx_next;

  always_comb begin
    cmd.op     = ulw_pkg::OP_NONE;
    cmd.idx    = idx;
    state_next = state;
    idx_next   = idx;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = sts.room;
        cmd.op   = ulw_pkg::OP_FLUSH;
        if (in_valid && sts.room) begin
          if (sts.need_replay) begin
            cmd.op     = ulw_pkg::OP_LOAD;
            state_next = S_REPLAY;
            idx_next   = 2'd0;
          end else begin
            cmd.op = ulw_pkg::OP_STEP;
            if (sts.in_last) begin
              state_next = S_FINAL;
            end
          end
        end
      end
      S_REPLAY: begin
        if (sts.room) begin
          cmd.op = ulw_pkg::OP_REPLAY;
          if (idx == sts.pcount - 2'd1) begin
            state_next = S_FRESH;
          end else begin
            idx_next = idx + 2'd1;
          end
        end
      end
      S_FRESH: begin
        if (sts.room) begin
          cmd.op     = ulw_pkg::OP_FRESH;
          state_next = sts.last_q ? S_FINAL : S_IDLE;
        end
      end
      S_FINAL: begin
        if (sts.room) begin
          cmd.op     = ulw_pkg::OP_FINAL;
          state_next = S_SUMMARY;
        end
      end
      S_SUMMARY: begin
        if (sts.room) begin
          cmd.op     = ulw_pkg::OP_SUMMARY;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= 2'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  a_replay_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPLAY) |-> (sts.pcount != 2'd0))
    else $error("replay step without pending bytes");

  a_replay_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPLAY) |-> (idx < sts.pcount))
    else $error("replay index beyond pending count");

  a_final_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL) |-> sts.last_q)
    else $error("final line step without a last byte");

endmodule

@@ hdl/ulw_datapath.sv @@
// ----------------------------------------------------------------------------
// ulw_datapath
// UTF-8 decoder, line fitting unit, run state, configuration registers and
// the two-entry record stage (staging register and output register).
// ----------------------------------------------------------------------------
module ulw_datapath #(
  parameter int OFFSET_BITS = 16,
  parameter int MAX_LINES   = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ulw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ulw_pkg::CFG_W-1:0]        cfg_data,
  input  logic [7:0]                       byte_value,
  input  logic                             last_byte,
  input  ulw_pkg::cmd_t                    cmd,
  output ulw_pkg::sts_t                    sts,
  ulw_rec_if.source                        rec_out
);

  localparam int LD_W  = $clog2(MAX_LINES + 1);
  localparam int CMP_W = (LD_W > ulw_pkg::LL_W) ? LD_W : ulw_pkg::LL_W;
  localparam int OB    = OFFSET_BITS;

  logic [ulw_pkg::LW_W-1:0] line_width;
  logic [ulw_pkg::GS_W-1:0] glyph_size;
  logic [ulw_pkg::LL_W-1:0] line_limit;

  logic [7:0]    pb [3];
  logic [1:0]    pcount;
  logic [1:0]    pcount_next;
  logic [OB-1:0] bpos;
  logic [OB-1:0] bpos_next;
  logic [OB-1:0] lsp;
  logic [OB-1:0] lsp_next;
  logic [OB-1:0] cons;
  logic [OB-1:0] cons_next;
  logic [OB-1:0] tcr;
  logic [OB-1:0] tcr_next;
  logic [12:0]   pix;
  logic [12:0]   pix_next;
  logic          ovh;
  logic          ovh_next;
  logic [LD_W-1:0] ld;
  logic [LD_W-1:0] ld_next;
  logic          halted;
  logic          halted_next;

  logic [7:0]    byte_q;
  logic          last_q;
  logic [OB-1:0] pos_q;
  logic          runok_q;

  ulw_pkg::rec_t hold;
  logic          hold_v;
  ulw_pkg::rec_t out_rec;
  logic          out_v;
  logic          out_eor;

  logic [CMP_W-1:0] eff_limit;
  logic             can_run;
  logic [LD_W-1:0]  ld_inc;
  logic             line_halts;
  logic             out_free;
  logic             room;
  logic             move;

  logic                    dec_en;
  logic [7:0]              dec_b;
  logic [OB-1:0]           dec_p;
  logic [1:0]              dec_pc;
  logic [2:0]              need_pend;
  logic [ulw_pkg::CP_W-1:0] asm_cp;
  logic                    pb_we;
  logic [1:0]              pb_idx;

  logic                    tc_en;
  logic [ulw_pkg::CP_W-1:0] tc_cp;
  logic [OB-1:0]           tc_cs;
  logic [2:0]              tc_nb;
  logic [7:0]              half_gs;
  logic [7:0]              w;
  logic                    overflow;
  logic                    brk;

  logic          pl_en;
  logic [OB-1:0] pl_end;
  logic          nl_en;
  logic [OB-1:0] nl_pos;
  logic          cont_en;
  logic [12:0]   cont_pix;
  logic [OB-1:0] cont_tcr;
  logic [OB-1:0] fin_pos;

  logic          rec_new;
  ulw_pkg::rec_t rec_d;

  assign eff_limit  = (CMP_W'(line_limit) < CMP_W'(MAX_LINES)) ?
                      CMP_W'(line_limit) : CMP_W'(MAX_LINES);
  assign can_run    = !halted && (line_width != '0) && (CMP_W'(ld) < eff_limit);
  assign ld_inc     = ld + LD_W'(1);
  assign line_halts = CMP_W'(ld_inc) >= eff_limit;
  assign out_free   = !out_v || rec_out.ready;
  assign room       = !hold_v || out_free;
  assign move       = hold_v && out_free && (cmd.op != ulw_pkg::OP_NONE);
  assign fin_pos    = bpos - OB'(pcount);

  assign sts.room        = room;
  assign sts.need_replay = can_run && (pcount != 2'd0) && !ulw_pkg::is_cont(byte_value);
  assign sts.in_last     = last_byte;
  assign sts.last_q      = last_q;
  assign sts.pcount      = pcount;

  assign need_pend = ulw_pkg::seq_len(pb[0]);
  assign half_gs   = glyph_size >> 1;

  always_comb begin
    case (need_pend)
      3'd2: asm_cp = {10'd0, pb[0][4:0], dec_b[5:0]};
      3'd3: asm_cp = {5'd0, pb[0][3:0], pb[1][5:0], dec_b[5:0]};
      default: asm_cp = {pb[0][2:0], pb[1][5:0], pb[2][5:0], dec_b[5:0]};
    endcase
  end

  always_comb begin
    if (glyph_size == '0) begin
      w = 8'd0;
    end else if (tc_cp < ulw_pkg::CP_ASCII_END) begin
      w = (half_gs == 8'd0) ? 8'd1 : half_gs;
    end else begin
      w = glyph_size;
    end
  end

  always_comb begin
    pcount_next = pcount;
    bpos_next   = bpos;
    lsp_next    = lsp;
    cons_next   = cons;
    tcr_next    = tcr;
    pix_next    = pix;
    ovh_next    = ovh;
    ld_next     = ld;
    halted_next = halted;
    dec_en      = 1'b0;
    dec_b       = byte_value;
    dec_p       = bpos;
    dec_pc      = pcount;
    pb_we       = 1'b0;
    pb_idx      = pcount;
    tc_en       = 1'b0;
    tc_cp       = ulw_pkg::CP_REPL;
    tc_cs       = bpos;
    tc_nb       = 3'd1;
    overflow    = 1'b0;
    brk         = 1'b0;
    pl_en       = 1'b0;
    pl_end      = bpos;
    nl_en       = 1'b0;
    nl_pos      = bpos;
    cont_en     = 1'b0;
    cont_pix    = pix;
    cont_tcr    = tcr;
    rec_new     = 1'b0;
    rec_d       = '0;

    case (cmd.op)
      ulw_pkg::OP_STEP: begin
        bpos_next = bpos + OB'(1);
        dec_en    = can_run;
      end
      ulw_pkg::OP_LOAD: begin
        bpos_next = bpos + OB'(1);
      end
      ulw_pkg::OP_REPLAY: begin
        tc_en = 1'b1;
        tc_cs = pos_q - OB'(pcount) + OB'(cmd.idx);
      end
      ulw_pkg::OP_FRESH: begin
        dec_en = runok_q;
        dec_b  = byte_q;
        dec_p  = pos_q;
        dec_pc = 2'd0;
        if (runok_q) begin
          pcount_next = 2'd0;
        end
      end
      default: begin
      end
    endcase

    if (dec_en) begin
      tc_cs = dec_p;
      if (dec_pc != 2'd0) begin
        if ({1'b0, dec_pc} + 3'd1 >= need_pend) begin
          tc_en       = 1'b1;
          tc_cp       = asm_cp;
          tc_cs       = dec_p + OB'(1) - OB'(need_pend);
          tc_nb       = need_pend;
          pcount_next = 2'd0;
        end else begin
          pb_we       = 1'b1;
          pb_idx      = dec_pc;
          pcount_next = dec_pc + 2'd1;
        end
      end else begin
        case (ulw_pkg::seq_len(dec_b))
          3'd1: begin
            tc_en = 1'b1;
            tc_cp = ulw_pkg::CP_W'(dec_b);
          end
          3'd0: begin
            tc_en = 1'b1;
            tc_cp = ulw_pkg::CP_REPL;
          end
          default: begin
            pb_we       = 1'b1;
            pb_idx      = 2'd0;
            pcount_next = 2'd1;
          end
        endcase
      end
    end

    if (tc_en && can_run) begin
      if (tc_cp == ulw_pkg::CP_LF) begin
        pl_en  = 1'b1;
        pl_end = tc_cs;
        nl_en  = 1'b1;
        nl_pos = tc_cs + OB'(tc_nb);
      end else begin
        overflow = ({1'b0, pix} + 14'(w) > 14'(line_width)) && (tc_cs != lsp);
        brk      = overflow && !(ulw_pkg::no_line_start(tc_cp) && !ovh);
        if (overflow && !brk) begin
          ovh_next = 1'b1;
        end
        if (brk) begin
          pl_en  = 1'b1;
          pl_end = tc_cs;
          nl_en  = 1'b1;
          nl_pos = tc_cs;
        end
        cont_en  = !(brk && line_halts);
        cont_pix = (brk ? 13'd0 : pix) + 13'(w);
        cont_tcr = (tc_cp == ulw_pkg::CP_CR) ? ((brk ? '0 : tcr) + OB'(1)) : '0;
      end
    end

    if (cmd.op == ulw_pkg::OP_FINAL && can_run && fin_pos != lsp) begin
      pl_en     = 1'b1;
      pl_end    = fin_pos;
      cons_next = fin_pos;
    end

    if (pl_en) begin
      rec_new        = 1'b1;
      rec_d.kind     = ulw_pkg::REC_LINE;
      rec_d.offset   = 16'(lsp);
      rec_d.length   = 16'(pl_end - lsp - tcr);
      ld_next        = ld_inc;
      halted_next    = line_halts;
    end
    if (nl_en) begin
      cons_next = nl_pos;
      lsp_next  = nl_pos;
      pix_next  = 13'd0;
      ovh_next  = 1'b0;
      tcr_next  = '0;
    end
    if (cont_en) begin
      pix_next = cont_pix;
      tcr_next = cont_tcr;
    end

    if (cmd.op == ulw_pkg::OP_SUMMARY) begin
      rec_new        = 1'b1;
      rec_d          = '0;
      rec_d.kind     = ulw_pkg::REC_SUMMARY;
      rec_d.consumed = 16'(cons);
      rec_d.count    = 7'(ld);
      pcount_next    = 2'd0;
      bpos_next      = '0;
      lsp_next       = '0;
      cons_next      = '0;
      tcr_next       = '0;
      pix_next       = 13'd0;
      ovh_next       = 1'b0;
      ld_next        = '0;
      halted_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= 12'd240;
      glyph_size <= 8'd16;
      line_limit <= 7'd16;
      pcount     <= 2'd0;
      bpos       <= '0;
      lsp        <= '0;
      cons       <= '0;
      tcr        <= '0;
      pix        <= 13'd0;
      ovh        <= 1'b0;
      ld         <= '0;
      halted     <= 1'b0;
      last_q     <= 1'b0;
      runok_q    <= 1'b0;
      hold_v     <= 1'b0;
      out_v      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          ulw_pkg::CFG_LINE_WIDTH: line_width <= cfg_data[ulw_pkg::LW_W-1:0];
          ulw_pkg::CFG_GLYPH_SIZE: glyph_size <= cfg_data[ulw_pkg::GS_W-1:0];
          ulw_pkg::CFG_LINE_LIMIT: line_limit <= cfg_data[ulw_pkg::LL_W-1:0];
          default: begin
          end
        endcase
      end
      pcount <= pcount_next;
      bpos   <= bpos_next;
      lsp    <= lsp_next;
      cons   <= cons_next;
      tcr    <= tcr_next;
      pix    <= pix_next;
      ovh    <= ovh_next;
      ld     <= ld_next;
      halted <= halted_next;
      if (cmd.op == ulw_pkg::OP_STEP || cmd.op == ulw_pkg::OP_LOAD) begin
        last_q  <= last_byte;
        runok_q <= can_run;
      end
      if (rec_new) begin
        hold_v <= 1'b1;
      end else if (move) begin
        hold_v <= 1'b0;
      end
      if (move) begin
        out_v <= 1'b1;
      end else if (rec_out.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pb_we) begin
      pb[pb_idx] <= dec_b;
    end
    if (cmd.op == ulw_pkg::OP_STEP || cmd.op == ulw_pkg::OP_LOAD) begin
      byte_q <= byte_value;
      pos_q  <= bpos;
    end
    if (rec_new) begin
      hold <= rec_d;
    end
    if (move) begin
      out_rec <= hold;
      out_eor <= (cmd.op == ulw_pkg::OP_FLUSH) || (cmd.op == ulw_pkg::OP_STEP) ||
                 (cmd.op == ulw_pkg::OP_LOAD);
    end
  end

  assign rec_out.valid          = out_v;
  assign rec_out.record_kind    = out_rec.kind;
  assign rec_out.line_offset    = out_rec.offset;
  assign rec_out.line_length    = out_rec.length;
  assign rec_out.bytes_consumed = out_rec.consumed;
  assign rec_out.line_count     = out_rec.count;
  assign rec_out.end_of_run     = out_eor;

  a_hold_not_lost: assert property (@(posedge clk) disable iff (rst)
    (rec_new && hold_v) |-> out_free)
    else $error("staged record overwritten before it moved out");

  a_summary_clears_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == ulw_pkg::OP_SUMMARY) |=> (bpos == '0 && ld == '0 && !halted))
    else $error("run state not cleared after summary");

  a_halt_needs_line: assert property (@(posedge clk) disable iff (rst)
    halted |-> (ld != '0))
    else $error("halted with no line emitted");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 line wrapper. Text buffers go in byte by
// byte over a valid/ready channel, and an in-bench copy of the wrapping rules
// predicts each line and summary record. Actual records are checked in order,
// field by field. Random content, register settings and random idle bursts on
// both channels run alongside directed cases: broken sequences, overhang,
// the line limit, zeroed registers, output back-pressure and offset wrap.
// ----------------------------------------------------------------------------
module tb_top;
  import ulw_pkg::*;

  localparam int MAX_LINES     = 64;
  localparam int MAX_RECS      = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 400;
  localparam int QUIET_LIMIT   = 3000;
  localparam int WRAP_BYTES    = 66000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [28:0][CP_W-1:0] NO_START_CP = {
    21'h003002, 21'h00FF0C, 21'h003001, 21'h00FF1B, 21'h00FF1A, 21'h00FF1F,
    21'h00FF01, 21'h00300B, 21'h00300D, 21'h00300F, 21'h00FF09, 21'h003011,
    21'h003015, 21'h00FF5D, 21'h002026, 21'h002014, 21'h00FF5E, 21'h0000B7,
    21'h002019, 21'h00201D, 21'h00002C, 21'h00002E, 21'h00003B, 21'h00003A,
    21'h00003F, 21'h000021, 21'h000029, 21'h00005D, 21'h00007D
  };

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic        kind;
    logic [15:0] offset;
    logic [15:0] length;
    logic [15:0] consumed;
    logic [6:0]  count;
    logic        eor;
  } line_rec_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  ulw_byte_if byte_if();
  ulw_rec_if  rec_if();

  utf8_line_wrapper_core #(
    .OFFSET_BITS(16),
    .MAX_LINES(MAX_LINES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .byte_in(byte_if),
    .rec_out(rec_if)
  );

  // Predicted register and run state.
  logic [11:0] cfg_width;
  logic [7:0]  cfg_glyph;
  logic [6:0]  cfg_limit;
  logic [7:0]  held [0:2];
  int          held_cnt;
  logic [15:0] byte_pos;
  logic [15:0] line_start;
  logic [15:0] consumed;
  logic [15:0] cr_run;
  int unsigned line_px;
  bit          overhang;
  bit          halted;
  int          lines_done;

  line_rec_t awaited_records[$];
  int        step_recs;

  bit idle_on;
  int rx_gap;
  int hold_reqs;
  int holds_served;
  int quiet_cycles;
  int mismatches;
  int bytes_sent;
  int live_bytes;
  int buffers_sent;
  int settings_used;
  int line_recs_seen;
  int summaries_seen;

  function automatic int line_cap();
    return (cfg_limit < MAX_LINES) ? int'(cfg_limit) : MAX_LINES;
  endfunction

  function automatic bit wrap_active();
    return !halted && cfg_width != 0 && lines_done < line_cap();
  endfunction

  function automatic int lead_len(logic [7:0] b);
    if (b < 8'h80) return 1;
    if ((b & 8'hE0) == 8'hC0) return 2;
    if ((b & 8'hF0) == 8'hE0) return 3;
    if ((b & 8'hF8) == 8'hF0) return 4;
    return 0;
  endfunction

  function automatic void push_rec(logic kind, logic [15:0] off, logic [15:0] len,
                                   logic [15:0] cons, logic [6:0] cnt);
    line_rec_t r;
    if (step_recs >= MAX_RECS) return;
    r.kind     = kind;
    r.offset   = off;
    r.length   = len;
    r.consumed = cons;
    r.count    = cnt;
    r.eor      = 1'b0;
    awaited_records.push_back(r);
    step_recs++;
  endfunction

  function automatic void close_line(logic [15:0] stop);
    push_rec(REC_LINE, line_start, stop - line_start - cr_run, 16'd0, 7'd0);
    lines_done++;
    if (lines_done >= line_cap()) halted = 1'b1;
  endfunction

  function automatic void open_line(logic [15:0] at);
    consumed   = at;
    line_start = at;
    line_px    = 0;
    overhang   = 1'b0;
    cr_run     = 16'd0;
  endfunction

  function automatic void clear_run();
    held_cnt   = 0;
    byte_pos   = 16'd0;
    lines_done = 0;
    halted     = 1'b0;
    open_line(16'd0);
  endfunction

  function automatic void place_char(logic [CP_W-1:0] cp, logic [15:0] cs, logic [15:0] nb);
    int unsigned w;
    bit          forbidden;
    if (!wrap_active()) return;
    if (cp == CP_LF) begin
      close_line(cs);
      open_line(cs + nb);
      return;
    end
    if (cfg_glyph == 0) begin
      w = 0;
    end else if (cp < CP_ASCII_END) begin
      w = (cfg_glyph / 2 > 0) ? cfg_glyph / 2 : 1;
    end else begin
      w = cfg_glyph;
    end
    forbidden = 1'b0;
    for (int k = 0; k < 29; k++) begin
      if (NO_START_CP[k] == cp) forbidden = 1'b1;
    end
    if (line_px + w > cfg_width && cs != line_start) begin
      if (forbidden && !overhang) begin
        overhang = 1'b1;
      end else begin
        close_line(cs);
        open_line(cs);
        if (!wrap_active()) return;
      end
    end
    line_px += w;
    cr_run = (cp == CP_CR) ? cr_run + 16'd1 : 16'd0;
  endfunction

  function automatic void feed_byte(logic [7:0] b, logic [15:0] p);
    int              need;
    logic [CP_W-1:0] v;
    logic [15:0]     first;
    if (held_cnt > 0) begin
      need = lead_len(held[0]);
      if (b[7:6] == 2'b10) begin
        if (held_cnt + 1 >= need) begin
          v = held[0] & ((need == 2) ? 8'h1F : (need == 3) ? 8'h0F : 8'h07);
          for (int k = 1; k < held_cnt && k < 3; k++) v = (v << 6) | held[k][5:0];
          v = (v << 6) | b[5:0];
          place_char(v, p + 16'd1 - 16'(need), 16'(need));
          held_cnt = 0;
        end else if (held_cnt < 3) begin
          held[held_cnt] = b;
          held_cnt++;
        end
        return;
      end
      first = p - 16'(held_cnt);
      for (int k = 0; k < held_cnt; k++) place_char(CP_REPL, first + 16'(k), 16'd1);
      held_cnt = 0;
    end
    need = lead_len(b);
    if (need == 1) begin
      place_char(21'(b), p, 16'd1);
    end else if (need == 0) begin
      place_char(CP_REPL, p, 16'd1);
    end else begin
      held[0]  = b;
      held_cnt = 1;
    end
  endfunction

  function automatic void wrap_byte(logic [7:0] b, logic last);
    logic [15:0] p;
    logic [15:0] stop;
    line_rec_t   tail;
    step_recs = 0;
    p = byte_pos;
    if (wrap_active()) begin
      live_bytes++;
      feed_byte(b, p);
    end
    byte_pos = p + 16'd1;
    if (last) begin
      stop = byte_pos - 16'(held_cnt);
      if (wrap_active() && stop != line_start) begin
        close_line(stop);
        consumed = stop;
      end
      push_rec(REC_SUMMARY, 16'd0, 16'd0, consumed, 7'(lines_done));
      clear_run();
    end
    if (step_recs > 0) begin
      tail = awaited_records.pop_back();
      tail.eor = 1'b1;
      awaited_records.push_back(tail);
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 30) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endfunction

  function automatic void append_cp(ref byte_q_t text, input logic [CP_W-1:0] cp);
    if (cp < 21'h80) begin
      text.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      text.push_back({3'b110, cp[10:6]});
      text.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      text.push_back({4'b1110, cp[15:12]});
      text.push_back({2'b10, cp[11:6]});
      text.push_back({2'b10, cp[5:0]});
    end else begin
      text.push_back({5'b11110, cp[20:18]});
      text.push_back({2'b10, cp[17:12]});
      text.push_back({2'b10, cp[11:6]});
      text.push_back({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void add_broken(ref byte_q_t text);
    int         n;
    logic [7:0] lead;
    n    = $urandom_range(2, 4);
    lead = 8'($urandom);
    case (n)
      2: begin
        lead = {3'b110, lead[4:0]};
      end
      3: begin
        lead = {4'b1110, lead[3:0]};
      end
      default: begin
        lead = {5'b11110, lead[2:0]};
      end
    endcase
    text.push_back(lead);
    repeat ($urandom_range(0, n - 2)) text.push_back({2'b10, 6'($urandom)});
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    byte_if.valid      <= 1'b1;
    byte_if.byte_value <= b;
    byte_if.last_byte  <= last;
    do @(posedge clk); while (!byte_if.ready);
    wrap_byte(b, last);
    bytes_sent++;
    if (last) buffers_sent++;
  endtask

  task automatic send_text(input byte_q_t text);
    foreach (text[k]) send_byte(text[k], k == text.size() - 1);
  endtask

  task automatic wait_idle();
    byte_if.valid <= 1'b0;
    while (awaited_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_LINE_WIDTH: begin
        cfg_width = data[11:0];
      end
      CFG_GLYPH_SIZE: begin
        cfg_glyph = data[7:0];
      end
      CFG_LINE_LIMIT: begin
        cfg_limit = data[6:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic configure(input logic [11:0] w, input logic [11:0] g, input logic [11:0] l);
    wait_idle();
    write_reg(CFG_LINE_WIDTH, w);
    write_reg(CFG_GLYPH_SIZE, g);
    write_reg(CFG_LINE_LIMIT, l);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    byte_q_t text;
    text = {8'h48, 8'h0D, 8'h0A, 8'hE3, 8'h80, 8'h82, 8'hFF, 8'hC3, 8'h00, 8'h80, 8'hF0};
    send_text(text);
  endtask

  task automatic test_long_sequences();
    byte_q_t text;
    configure(12'd4095, 12'd255, 12'd64);
    text = {8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'h0A};
    send_text(text);
  endtask

  task automatic test_overhang_and_halt();
    byte_q_t text;
    configure(12'd16, 12'd16, 12'd2);
    text = {8'h61, 8'h62, 8'h2C, 8'h63, 8'h64, 8'h65, 8'h66};
    send_text(text);
  endtask

  task automatic test_zero_registers();
    byte_q_t text;
    configure(12'd0, 12'd16, 12'd16);
    @(posedge clk);
    write_reg(CFG_UNUSED, 12'hFFF);
    cfg_write <= 1'b0;
    text = {8'h61};
    send_text(text);
    configure(12'd240, 12'd0, 12'd16);
    text = {8'h61, 8'h62};
    send_text(text);
    configure(12'd240, 12'd16, 12'd0);
    text = {8'h0A};
    send_text(text);
  endtask

  task automatic test_backpressure();
    configure(12'd4095, 12'd16, 12'd64);
    hold_reqs <= hold_reqs + 1;
    for (int k = 0; k < 25; k++) begin
      send_byte(8'h78, 1'b0);
      send_byte(CP_LF[7:0], k == 24);
    end
    wait_idle();
  endtask

  task automatic test_random_text(input int target);
    byte_q_t     text;
    int          start_count;
    int          bufs;
    int          pick;
    logic [11:0] w;
    logic [11:0] g;
    logic [11:0] l;
    start_count = live_bytes;
    bufs        = 0;
    while (live_bytes - start_count < target) begin
      if (bufs % 3 == 0) begin
        pick = $urandom_range(0, 9);
        w = (pick == 0) ? 12'd4095 : (pick == 1) ? 12'd1 : 12'($urandom_range(8, 160));
        pick = $urandom_range(0, 9);
        g = (pick == 0) ? 12'd255 : (pick == 1) ? 12'd0 : (pick == 2) ? 12'd1 :
            12'($urandom_range(2, 32));
        if ($urandom_range(0, 9) == 0) g[11:8] = 4'($urandom_range(1, 15));
        pick = $urandom_range(0, 11);
        l = (pick == 0) ? 12'd127 : (pick == 1) ? 12'd64 : (pick == 2) ? 12'd1 :
            12'($urandom_range(2, 20));
        configure(w, g, l);
      end
      text = {};
      repeat ($urandom_range(1, 14)) begin
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
          text.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end else if (pick < 54) begin
          append_cp(text, NO_START_CP[$urandom_range(0, 28)]);
        end else if (pick < 62) begin
          text.push_back(CP_LF[7:0]);
        end else if (pick < 67) begin
          text.push_back(CP_CR[7:0]);
        end else if (pick < 77) begin
          append_cp(text, 21'($urandom_range(21'h80, 21'h7FF)));
        end else if (pick < 87) begin
          append_cp(text, 21'($urandom_range(21'h800, 21'hFFFF)));
        end else if (pick < 91) begin
          append_cp(text, 21'($urandom_range(21'h10000, 21'h1FFFFF)));
        end else if (pick < 96) begin
          add_broken(text);
        end else begin
          text.push_back(8'($urandom));
        end
      end
      if ($urandom_range(0, 7) == 0) add_broken(text);
      send_text(text);
      bufs++;
    end
  endtask

  task automatic test_offset_wrap();
    configure(12'd4095, 12'd0, 12'd1);
    for (int k = 0; k < WRAP_BYTES - 2; k++) send_byte(8'h61 + 8'(k % 26), 1'b0);
    send_byte(CP_CR[7:0], 1'b0);
    send_byte(CP_CR[7:0], 1'b1);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rx_gap       = 0;
    holds_served = 0;
    rec_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_served) begin
        holds_served++;
        rx_gap = LONG_HOLD;
      end
      if (rx_gap > 0) begin
        rec_if.ready <= 1'b0;
        rx_gap--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rec_if.ready <= 1'b0;
        rx_gap = $urandom_range(0, 8);
      end else begin
        rec_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    line_rec_t want;
    if (!rst && rec_if.valid && rec_if.ready) begin
      if (rec_if.record_kind == REC_SUMMARY) summaries_seen++;
      else line_recs_seen++;
      if (awaited_records.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected record, expected none, actual kind %0d offset %0d length %0d",
                 $time, rec_if.record_kind, rec_if.line_offset, rec_if.line_length);
      end else begin
        want = awaited_records.pop_front();
        check_field("record_kind", 16'(want.kind), 16'(rec_if.record_kind));
        check_field("line_offset", want.offset, rec_if.line_offset);
        check_field("line_length", want.length, rec_if.line_length);
        check_field("bytes_consumed", want.consumed, rec_if.bytes_consumed);
        check_field("line_count", 16'(want.count), 16'(rec_if.line_count));
        check_field("end_of_run", 16'(want.eor), 16'(rec_if.end_of_run));
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_write || (byte_if.valid && byte_if.ready) ||
          (rec_if.valid && rec_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t ns: no request moved for %0d cycles", $time, QUIET_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst                <= 1'b1;
    cfg_write          <= 1'b0;
    cfg_index          <= CFG_LINE_WIDTH;
    cfg_data           <= '0;
    byte_if.valid      <= 1'b0;
    byte_if.byte_value <= 8'h00;
    byte_if.last_byte  <= 1'b0;
    hold_reqs          <= 0;
    idle_on        = 1'b1;
    mismatches     = 0;
    bytes_sent     = 0;
    live_bytes     = 0;
    buffers_sent   = 0;
    settings_used  = 1;
    line_recs_seen = 0;
    summaries_seen = 0;
    cfg_width      = 12'd240;
    cfg_glyph      = 8'd16;
    cfg_limit      = 7'd16;
    held[0]        = 8'h00;
    held[1]        = 8'h00;
    held[2]        = 8'h00;
    clear_run();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_long_sequences();
    test_overhang_and_halt();
    test_zero_registers();
    test_backpressure();
    test_random_text(160);
    idle_on = 1'b0;
    test_random_text(40);
    test_offset_wrap();
    wait_idle();

    $display("Sent %0d text bytes in %0d buffers under %0d register settings.",
             bytes_sent, buffers_sent, settings_used);
    $display("Checked %0d line records and %0d summaries, with stalls and offset wrap.",
             line_recs_seen, summaries_seen);
    if (mismatches == 0 && awaited_records.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ utf8_line_wrapper_core.f @@
hdl/ulw_pkg.sv
hdl/ulw_if.sv
hdl/ulw_ctrl.sv
hdl/ulw_datapath.sv
hdl/utf8_line_wrapper_core.sv
bench/tb_top.sv
